// ===== rtl/core/qpc_pkg.sv =====
// Package for the quadrature position counter: command and register codes,
// counting modes, field widths and reset values. No dependencies.
`timescale 1ns / 1ps

package qpc_pkg;

    localparam int unsigned NUM_CHANNELS_DEFAULT = 6;
    localparam int unsigned COUNT_WIDTH_DEFAULT = 32;

    localparam int unsigned CHANNEL_WIDTH = 3;
    localparam int unsigned POSITION_WIDTH = 32;
    localparam int unsigned MODES_WIDTH = 12;
    localparam int unsigned DELTA_WIDTH = 8;
    localparam int unsigned ENABLE_WIDTH = 6;
    localparam int unsigned CFG_DATA_WIDTH = 12;
    localparam int unsigned CFG_INDEX_WIDTH = 2;

    localparam logic [MODES_WIDTH-1:0] MODES_RESET = 12'd2640;
    localparam logic signed [DELTA_WIDTH-1:0] DELTA_RESET = 8'sd1;
    localparam logic [ENABLE_WIDTH-1:0] ENABLE_RESET = 6'd63;

    typedef enum logic [1:0] {
        CMD_EDGE  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CHANNEL_MODES  = 2'd0,
        REG_TICK_DELTA     = 2'd1,
        REG_CHANNEL_ENABLE = 2'd2
    } cfg_reg_t;

    localparam logic [1:0] MODE_RISING = 2'd0;
    localparam logic [1:0] MODE_LATCHED = 2'd1;
    localparam logic [1:0] MODE_BOTH = 2'd2;

endpackage

// ===== rtl/core/quadrature_position_counter_top.sv =====
// Top level of the quadrature position counter: per-channel counters, B latches,
// configuration registers and a two-entry result buffer. Depends on qpc_pkg.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    s_command, s_channel, s_a_level, s_b_level
//   m_        out        m_valid / m_ready    m_position
//   cfg_      in         cfg_wr_en            cfg_index, cfg_wdata
//
// Each request is decoded and applied to its channel's count in the cycle it is
// accepted; its result is registered into m_position, or into the skid entry on a stall.
// One request per cycle while s_ready is high; the limit is one add/subtract per count.
// The two-entry result buffer holds s_ready high until a stall fills the skid entry.
// Reset clears all counts, latches and the result buffer and loads the register defaults.
`timescale 1ns / 1ps

module quadrature_position_counter_top #(
    parameter int unsigned NUM_CHANNELS = qpc_pkg::NUM_CHANNELS_DEFAULT,
    parameter int unsigned COUNT_WIDTH = qpc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [1:0]                               s_command,
    input  logic [qpc_pkg::CHANNEL_WIDTH-1:0]        s_channel,
    input  logic                                     s_a_level,
    input  logic                                     s_b_level,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [qpc_pkg::POSITION_WIDTH-1:0] m_position,
    input  logic                                     cfg_wr_en,
    input  logic [qpc_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  logic [qpc_pkg::CFG_DATA_WIDTH-1:0]       cfg_wdata
);

    localparam int unsigned CH_IDX_WIDTH = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int unsigned CMP_WIDTH = 5;

    logic [qpc_pkg::MODES_WIDTH-1:0]         channel_modes_reg;
    logic signed [qpc_pkg::DELTA_WIDTH-1:0]  tick_delta_reg;
    logic [qpc_pkg::ENABLE_WIDTH-1:0]        channel_enable_reg;

    logic [COUNT_WIDTH-1:0]                  count_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]                 latched_b_reg;

    logic                                    m_valid_reg;
    logic [qpc_pkg::POSITION_WIDTH-1:0]      m_position_reg;
    logic                                    skid_valid_reg;
    logic [qpc_pkg::POSITION_WIDTH-1:0]      skid_position_reg;

    logic                                    s_accept;
    logic                                    ch_ok;
    logic [CH_IDX_WIDTH-1:0]                 ch_idx;
    logic [1:0]                              mode;
    logic                                    enabled;
    logic [COUNT_WIDTH-1:0]                  delta_ext;
    logic [COUNT_WIDTH-1:0]                  cur_count;
    logic                                    cur_latch;
    logic                                    count_up;
    logic                                    count_down;
    logic                                    latch_write;
    logic                                    clear_count;
    logic [COUNT_WIDTH-1:0]                  count_next;
    logic [qpc_pkg::POSITION_WIDTH-1:0]      result_position;

    assign s_ready = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_position = m_position_reg;

    assign ch_ok = CMP_WIDTH'(s_channel) < CMP_WIDTH'(NUM_CHANNELS);
    assign ch_idx = CH_IDX_WIDTH'(s_channel);
    assign mode = 2'(channel_modes_reg >> {s_channel, 1'b0});
    assign enabled = 1'(channel_enable_reg >> s_channel);
    assign delta_ext = COUNT_WIDTH'(tick_delta_reg);
    assign cur_count = count_reg[ch_idx];
    assign cur_latch = latched_b_reg[ch_idx];

    // Decode the request into a count step, a latch write or a clear.
    always_comb begin
        count_up = 1'b0;
        count_down = 1'b0;
        latch_write = 1'b0;
        clear_count = 1'b0;
        unique case (s_command)
            qpc_pkg::CMD_EDGE: begin
                if (enabled) begin
                    if (s_a_level) begin
                        if ((mode != qpc_pkg::MODE_LATCHED) || (cur_latch != s_b_level)) begin
                            count_up = s_b_level;
                            count_down = !s_b_level;
                        end
                    end else if (mode == qpc_pkg::MODE_LATCHED) begin
                        latch_write = 1'b1;
                    end else if (mode == qpc_pkg::MODE_BOTH) begin
                        count_up = !s_b_level;
                        count_down = s_b_level;
                    end
                end
            end
            qpc_pkg::CMD_CLEAR: begin
                clear_count = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        priority if (clear_count) begin
            count_next = '0;
        end else if (count_up) begin
            count_next = cur_count + delta_ext;
        end else if (count_down) begin
            count_next = cur_count - delta_ext;
        end else begin
            count_next = cur_count;
        end
    end

    assign result_position = ch_ok ? qpc_pkg::POSITION_WIDTH'($signed(count_next)) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_modes_reg <= qpc_pkg::MODES_RESET;
            tick_delta_reg <= qpc_pkg::DELTA_RESET;
            channel_enable_reg <= qpc_pkg::ENABLE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                qpc_pkg::REG_CHANNEL_MODES: begin
                    channel_modes_reg <= cfg_wdata[qpc_pkg::MODES_WIDTH-1:0];
                end
                qpc_pkg::REG_TICK_DELTA: begin
                    tick_delta_reg <= cfg_wdata[qpc_pkg::DELTA_WIDTH-1:0];
                end
                qpc_pkg::REG_CHANNEL_ENABLE: begin
                    channel_enable_reg <= cfg_wdata[qpc_pkg::ENABLE_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                count_reg[i] <= '0;
            end
            latched_b_reg <= '0;
        end else if (s_accept && ch_ok) begin
            count_reg[ch_idx] <= count_next;
            if (latch_write) begin
                latched_b_reg[ch_idx] <= s_b_level;
            end
        end
    end

    // Result buffer: the main register feeds m_position, the skid entry
    // catches a result that arrives while the main register is stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg <= 1'b1;
                m_position_reg <= skid_position_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= s_accept;
                if (s_accept) begin
                    m_position_reg <= result_position;
                end
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
            skid_position_reg <= result_position;
        end
    end

    a_skid_implies_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("Skid entry holds a result while the main register is empty.");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg)
        else $error("Accepted request left no result in the output register.");

    a_clear_zeroes_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && ch_ok && (s_command == qpc_pkg::CMD_CLEAR))
            |=> (count_reg[$past(ch_idx)] == '0))
        else $error("Clear request did not zero the channel count.");

    a_latch_only_on_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_accept || (s_command != qpc_pkg::CMD_EDGE)) |=> $stable(latched_b_reg))
        else $error("B latch changed without an accepted edge request.");

endmodule
